FILE: rtl/core/c3vs_pkg.sv
// ----------------------------------------------------------------------------
// c3vs_pkg
// Shared constants, register indexes and sizing helpers for the 3x3
// valid-region convolution stream.
// ----------------------------------------------------------------------------
package c3vs_pkg;

   // default sizing of the block
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int PIXEL_BITS_DEF = 8;
   localparam int COEF_BITS_DEF  = 8;

   // kernel is 3x3; nine products need four more bits in the sum
   localparam int KSIZE       = 3;
   localparam int SUM_GROWTH  = 4;

   // geometry registers
   localparam int WIDTH_BITS   = 11;
   localparam int HEIGHT_BITS  = 13;
   localparam int ROW_BITS     = 12;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MIN_DIM      = 3;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KERNEL_TOP    = 3'd0,
      CSR_KERNEL_MIDDLE = 3'd1,
      CSR_KERNEL_BOTTOM = 3'd2,
      CSR_IMAGE_WIDTH   = 3'd3,
      CSR_IMAGE_HEIGHT  = 3'd4
   } csr_index_type;

   // write data is as wide as the widest register
   function automatic int csr_data_bits(input int coef_bits);
      int krow;
      krow = KSIZE * coef_bits;
      return (krow > HEIGHT_BITS) ? krow : HEIGHT_BITS;
   endfunction

   // width of the correlation sum
   function automatic int out_bits(input int pixel_bits, input int coef_bits);
      return pixel_bits + coef_bits + SUM_GROWTH;
   endfunction

endpackage

FILE: rtl/core/c3vs_stream_if.sv
// ----------------------------------------------------------------------------
// c3vs stream interfaces
// Valid/ready channels for the pixel input and the filtered result output.
// ----------------------------------------------------------------------------

// pixel channel: one pixel per transfer, raster order
interface c3vs_req_if #(
   parameter int PIXEL_BITS = c3vs_pkg::PIXEL_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  frame_start;

   modport source (output valid, pixel, frame_start, input ready);
   modport sink   (input valid, pixel, frame_start, output ready);
endinterface

// result channel: one filtered value per transfer
interface c3vs_rsp_if #(
   parameter int OUT_BITS = c3vs_pkg::out_bits(c3vs_pkg::PIXEL_BITS_DEF,
                                               c3vs_pkg::COEF_BITS_DEF)
);
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] filtered_value;
   logic                       row_end;
   logic                       frame_end;

   modport source (output valid, filtered_value, row_end, frame_end, input ready);
   modport sink   (input valid, filtered_value, row_end, frame_end, output ready);
endinterface

FILE: rtl/core/c3vs_line_store.sv
// ----------------------------------------------------------------------------
// c3vs_line_store
// Single-port-write, single-port-read line memory with registered read data
// and a bypass for a write to the address being read in the same cycle.
// ----------------------------------------------------------------------------
module c3vs_line_store #(
   parameter int DEPTH     = c3vs_pkg::MAX_WIDTH_DEF,
   parameter int DATA_BITS = 2 * c3vs_pkg::PIXEL_BITS_DEF,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic [DATA_BITS-1:0] rd_data
);
   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] q_ff;
   logic [DATA_BITS-1:0] byp_ff;
   logic                 hit_ff;
   logic                 hit_in;

   // same-address write in the read cycle: memory returns old data
   assign hit_in = wr_en && (wr_addr == rd_addr);

   // memory array and read register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff   <= mem[rd_addr];
         byp_ff <= wr_data;
      end
   end

   // bypass select flag
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= hit_in;
      end
   end

   assign rd_data = hit_ff ? byp_ff : q_ff;

endmodule

FILE: rtl/core/conv3x3_valid_stream.sv
// ----------------------------------------------------------------------------
// conv3x3_valid_stream
// 3x3 correlation over a raster pixel stream, valid region only.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle and returns one result per cycle while the result
// output is not held back by ready, for every pixel that completes a 3x3 window
// (row >= 2 and column >= 2), so a frame of H by W pixels gives (H-2) by
// (W-2) results, with row_end on the last result of a row and frame_end on
// the last result of the frame. The line memory read (both previous rows
// live in one 2-pixel-wide word per column) is registered together with the
// pixel, then the nine coefficient products are registered, and then the sum
// lands in the output register. The pipeline collapses bubbles, so input is
// taken while a result waits as long as a stage ahead is free. Line memory
// contents are undefined after reset; no clearing pass is run. Kernel and
// geometry registers should be written while the stream is idle.
// ----------------------------------------------------------------------------
module conv3x3_valid_stream #(
   parameter int MAX_WIDTH  = c3vs_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = c3vs_pkg::PIXEL_BITS_DEF,
   parameter int COEF_BITS  = c3vs_pkg::COEF_BITS_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              csr_we,
   input  logic [c3vs_pkg::CSR_INDEX_BITS-1:0]               csr_index,
   input  logic [c3vs_pkg::csr_data_bits(COEF_BITS)-1:0]     csr_wdata,
   c3vs_req_if.sink                                          req_stream,
   c3vs_rsp_if.source                                        rsp_stream
);
   import c3vs_pkg::*;

   localparam int KROW_BITS = KSIZE * COEF_BITS;
   localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int LEN_BITS  = (COL_BITS + 1 > WIDTH_BITS) ? COL_BITS + 1 : WIDTH_BITS;
   localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
   localparam int SUM_BITS  = PROD_BITS + SUM_GROWTH;
   localparam int WORD_BITS = 2 * PIXEL_BITS;

   localparam logic [KROW_BITS-1:0] KMID_RESET = KROW_BITS'(1) << COEF_BITS;

   // configuration registers
   logic [KROW_BITS-1:0]   kern_ff [KSIZE];
   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;

   // geometry limits and counters
   logic [LEN_BITS-1:0]    width_ext;
   logic [LEN_BITS-1:0]    width_lim;
   logic [HEIGHT_BITS-1:0] height_lim;
   logic [COL_BITS-1:0]    col_ff, col_cur, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_cur, row_in;
   logic                   last_col, last_row, emit;
   logic                   accept;

   // stage 1: line memory read in flight
   logic                   v1_ff;
   logic [PIXEL_BITS-1:0]  px1_ff;
   logic [COL_BITS-1:0]    addr1_ff;
   logic                   emit1_ff, row_end1_ff, frame_end1_ff;
   logic [WORD_BITS-1:0]   rd_word;
   logic [PIXEL_BITS-1:0]  above1, above2;
   logic                   leave1;

   // window and products
   logic [PIXEL_BITS-1:0]        window_ff [KSIZE][KSIZE];
   logic [PIXEL_BITS-1:0]        window_in [KSIZE][KSIZE];
   logic signed [PIXEL_BITS:0]   pix_s     [KSIZE][KSIZE];
   logic signed [COEF_BITS-1:0]  coef_s    [KSIZE][KSIZE];
   logic signed [PROD_BITS:0]    full_prod [KSIZE][KSIZE];
   logic signed [PROD_BITS-1:0]  prod_in   [KSIZE][KSIZE];

   // stage 2: products
   logic                         v2_ff;
   logic signed [PROD_BITS-1:0]  prod_ff   [KSIZE][KSIZE];
   logic                         row_end2_ff, frame_end2_ff;
   logic                         s2_free;

   // stage 3: output register
   logic                         v3_ff;
   logic signed [SUM_BITS-1:0]   sum_in, sum_ff;
   logic                         row_end3_ff, frame_end3_ff;
   logic                         free3, load3;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kern_ff[0] <= '0;
         kern_ff[1] <= KMID_RESET;
         kern_ff[2] <= '0;
         width_ff   <= WIDTH_BITS'(WIDTH_RESET);
         height_ff  <= HEIGHT_BITS'(HEIGHT_RESET);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KERNEL_TOP:    kern_ff[0] <= csr_wdata[KROW_BITS-1:0];
            CSR_KERNEL_MIDDLE: kern_ff[1] <= csr_wdata[KROW_BITS-1:0];
            CSR_KERNEL_BOTTOM: kern_ff[2] <= csr_wdata[KROW_BITS-1:0];
            CSR_IMAGE_WIDTH:   width_ff   <= csr_wdata[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT:  height_ff  <= csr_wdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp geometry to the supported range
   assign width_ext = LEN_BITS'(width_ff);
   always_comb begin
      priority if (width_ext < LEN_BITS'(MIN_DIM)) begin
         width_lim = LEN_BITS'(MIN_DIM);
      end else if (width_ext > LEN_BITS'(MAX_WIDTH)) begin
         width_lim = LEN_BITS'(MAX_WIDTH);
      end else begin
         width_lim = width_ext;
      end
      priority if (height_ff < HEIGHT_BITS'(MIN_DIM)) begin
         height_lim = HEIGHT_BITS'(MIN_DIM);
      end else if (height_ff > HEIGHT_BITS'(MAX_HEIGHT)) begin
         height_lim = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         height_lim = height_ff;
      end
   end

   // pipeline flow control
   assign free3   = !v3_ff || rsp_stream.ready;
   assign load3   = v2_ff && free3;
   assign s2_free = !v2_ff || free3;
   assign leave1  = v1_ff && s2_free;
   assign req_stream.ready = !v1_ff || leave1;
   assign accept  = req_stream.valid && req_stream.ready;

   // raster position of the incoming pixel
   always_comb begin
      col_cur  = req_stream.frame_start ? '0 : col_ff;
      row_cur  = req_stream.frame_start ? '0 : row_ff;
      last_col = (LEN_BITS'(col_cur) + LEN_BITS'(1)) >= width_lim;
      last_row = (HEIGHT_BITS'(row_cur) + HEIGHT_BITS'(1)) >= height_lim;
      emit     = (row_cur >= ROW_BITS'(KSIZE - 1)) && (col_cur >= COL_BITS'(KSIZE - 1));
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_cur + ROW_BITS'(1);
      end else begin
         col_in = col_cur + COL_BITS'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (accept) begin
         v1_ff <= 1'b1;
      end else if (leave1) begin
         v1_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px1_ff        <= req_stream.pixel;
         addr1_ff      <= col_cur;
         emit1_ff      <= emit;
         row_end1_ff   <= last_col;
         frame_end1_ff <= last_col && last_row;
      end
   end

   // line memory: upper half is two rows up, lower half one row up
   c3vs_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (WORD_BITS),
      .ADDR_BITS (COL_BITS)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .wr_en   (leave1),
      .wr_addr (addr1_ff),
      .wr_data ({above1, px1_ff}),
      .rd_data (rd_word)
   );

   assign above2 = rd_word[WORD_BITS-1:PIXEL_BITS];
   assign above1 = rd_word[PIXEL_BITS-1:0];

   // window shift and coefficient products
   always_comb begin
      for (int r = 0; r < KSIZE; r++) begin
         for (int c = 0; c < KSIZE - 1; c++) begin
            window_in[r][c] = window_ff[r][c+1];
         end
      end
      window_in[0][KSIZE-1] = above2;
      window_in[1][KSIZE-1] = above1;
      window_in[2][KSIZE-1] = px1_ff;
      for (int r = 0; r < KSIZE; r++) begin
         for (int c = 0; c < KSIZE; c++) begin
            pix_s[r][c]     = $signed({1'b0, window_in[r][c]});
            coef_s[r][c]    = $signed(kern_ff[r][c*COEF_BITS +: COEF_BITS]);
            full_prod[r][c] = pix_s[r][c] * coef_s[r][c];
            prod_in[r][c]   = full_prod[r][c][PROD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
               window_ff[r][c] <= '0;
            end
         end
      end else if (leave1) begin
         window_ff <= window_in;
      end
   end

   // stage 2 register: only windows that complete carry on
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (s2_free) begin
         v2_ff <= leave1 && emit1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (leave1) begin
         prod_ff       <= prod_in;
         row_end2_ff   <= row_end1_ff;
         frame_end2_ff <= frame_end1_ff;
      end
   end

   // sum of the nine products
   always_comb begin
      sum_in = '0;
      for (int r = 0; r < KSIZE; r++) begin
         for (int c = 0; c < KSIZE; c++) begin
            sum_in = sum_in + SUM_BITS'(prod_ff[r][c]);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (free3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         sum_ff        <= sum_in;
         row_end3_ff   <= row_end2_ff;
         frame_end3_ff <= frame_end2_ff;
      end
   end

   assign rsp_stream.valid          = v3_ff;
   assign rsp_stream.filtered_value = sum_ff;
   assign rsp_stream.row_end        = row_end3_ff;
   assign rsp_stream.frame_end      = frame_end3_ff;

endmodule
